@@ src/mexp_pkg.sv @@
// Shared types for the modular exponentiation core.
`timescale 1ns / 1ps

package mexp_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL_START,
        S_MUL
    } t_state;

    // Register index within the configuration space.
    localparam logic REG_MODULUS = 1'b0;

endpackage

@@ src/modular_exponentiation_core.sv @@
// Top level of the modular exponentiation core: control, registers, APB port.
`timescale 1ns / 1ps

// Computes base**exponent mod modulus for a signed WIDTH-bit base and an
// unsigned WIDTH-bit exponent, with the result in 0 .. modulus-1. An item is
// taken when start is high while busy is low; busy then stays high until the
// result appears on o_power_mod for exactly one cycle with o_valid high, and
// the receiver must take it in that cycle. Every item takes the same time:
// the base is first reduced one bit per cycle, then every one of the WIDTH
// exponent bits costs one pass of the bit-serial multiplier. The multiplier
// forms the multiply and the square of a step side by side, so that pass sets
// the rate. The modulus is written over APB at byte address 0 (64-bit data);
// the user must write it only while busy is low, as the core does not enforce
// this. A modulus of zero makes every result zero.
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_base,
    input  logic [WIDTH-1:0] i_exponent,

    output logic             o_valid,
    output logic [WIDTH-2:0] o_power_mod,

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

    t_state           r_state;
    t_state           n_state;
    logic [WIDTH-2:0] r_modulus;
    logic [WIDTH-1:0] r_exp;
    logic [WIDTH-1:0] n_exp;
    logic [WIDTH-2:0] r_acc;
    logic [WIDTH-2:0] n_acc;
    logic [WIDTH-2:0] r_sq;
    logic [WIDTH-2:0] n_sq;
    logic             r_neg;
    logic             n_neg;
    logic [CW-1:0]    r_bitcnt;
    logic [CW-1:0]    n_bitcnt;
    logic             r_valid;
    logic             n_valid;
    logic [WIDTH-2:0] r_result;
    logic [WIDTH-2:0] n_result;

    logic             s_red_load;
    logic [WIDTH-1:0] s_red_value;
    logic             s_red_done;
    logic [WIDTH-2:0] s_red_rem;
    logic             s_mul_load;
    logic             s_mul_done;
    logic [WIDTH-2:0] s_prod_acc;
    logic [WIDTH-2:0] s_prod_sq;
    logic             s_accept;
    logic             s_cfg_wr;

    // Configuration port.
    assign pready   = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite && (paddr[3] == REG_MODULUS);
    assign prdata   = (paddr[3] == REG_MODULUS) ? 64'(r_modulus) : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= (WIDTH-1)'(2);
        end else if (s_cfg_wr) begin
            r_modulus <= pwdata[WIDTH-2:0];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign s_accept = start && !busy;

    // A negative base is reduced through its magnitude and mirrored below.
    assign s_red_value = i_base[WIDTH-1] ? (~i_base + 1'b1) : i_base;

    mexp_reduce #(
        .WIDTH(WIDTH)
    ) u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_red_load),
        .i_value  (s_red_value),
        .i_modulus(r_modulus),
        .o_done   (s_red_done),
        .o_rem    (s_red_rem)
    );

    mexp_mulmod #(
        .WIDTH(WIDTH)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (s_mul_load),
        .i_acc     (r_acc),
        .i_sq      (r_sq),
        .i_modulus (r_modulus),
        .o_done    (s_mul_done),
        .o_prod_acc(s_prod_acc),
        .o_prod_sq (s_prod_sq)
    );

    always_comb begin
        n_state    = r_state;
        n_exp      = r_exp;
        n_acc      = r_acc;
        n_sq       = r_sq;
        n_neg      = r_neg;
        n_bitcnt   = r_bitcnt;
        n_valid    = 1'b0;
        n_result   = r_result;
        s_red_load = 1'b0;
        s_mul_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_exp      = i_exponent;
                    n_neg      = i_base[WIDTH-1];
                    s_red_load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (s_red_done) begin
                    if (r_neg && (s_red_rem != '0)) begin
                        n_sq = r_modulus - s_red_rem;
                    end else begin
                        n_sq = s_red_rem;
                    end
                    // One reduced modulo the modulus; zero when the modulus is one.
                    n_acc    = (r_modulus == (WIDTH-1)'(1)) ? '0 : (WIDTH-1)'(1);
                    n_bitcnt = '0;
                    n_state  = S_MUL_START;
                end
            end
            S_MUL_START: begin
                s_mul_load = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                if (s_mul_done) begin
                    if (r_exp[0]) begin
                        n_acc = s_prod_acc;
                    end
                    n_sq     = s_prod_sq;
                    n_exp    = {1'b0, r_exp[WIDTH-1:1]};
                    n_bitcnt = r_bitcnt + 1'b1;
                    if (r_bitcnt == LAST_BIT) begin
                        n_valid = 1'b1;
                        if (r_modulus == '0) begin
                            n_result = '0;
                        end else if (r_exp[0]) begin
                            n_result = s_prod_acc;
                        end else begin
                            n_result = r_acc;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MUL_START;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_bitcnt <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_bitcnt <= n_bitcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp    <= n_exp;
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_neg    <= n_neg;
        r_result <= n_result;
    end

    assign o_valid     = r_valid;
    assign o_power_mod = r_result;

endmodule

@@ src/mexp_reduce.sv @@
// Bit-serial reduction of a word modulo the configured modulus.
`timescale 1ns / 1ps

module mexp_reduce #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-2:0] i_modulus,
    output logic             o_done,
    output logic [WIDTH-2:0] o_rem
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST_STEP = CW'(WIDTH - 1);

    logic             r_run;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_val;
    logic [WIDTH-2:0] r_rem;

    logic [WIDTH-1:0] s_shift;
    logic [WIDTH-1:0] s_diff;
    logic [WIDTH-2:0] n_rem;

    // One quotient bit per cycle, most significant bit of the value first.
    always_comb begin
        s_shift = {r_rem, r_val[WIDTH-1]};
        s_diff  = s_shift - {1'b0, i_modulus};
        if (s_shift >= {1'b0, i_modulus}) begin
            n_rem = s_diff[WIDTH-2:0];
        end else begin
            n_rem = s_shift[WIDTH-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_run) begin
            r_val <= {r_val[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ src/mexp_mulmod.sv @@
// Dual bit-serial modular multiplier: forms a*s and s*s mod m together.
`timescale 1ns / 1ps

module mexp_mulmod #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [WIDTH-2:0] i_acc,
    input  logic [WIDTH-2:0] i_sq,
    input  logic [WIDTH-2:0] i_modulus,
    output logic             o_done,
    output logic [WIDTH-2:0] o_prod_acc,
    output logic [WIDTH-2:0] o_prod_sq
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST_STEP = CW'(WIDTH - 2);

    logic             r_run;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-2:0] r_addend;
    logic [WIDTH-2:0] r_mul_acc;
    logic [WIDTH-2:0] r_mul_sq;
    logic [WIDTH-2:0] r_pa;
    logic [WIDTH-2:0] r_ps;

    logic [WIDTH-1:0] s_mod;
    logic [WIDTH-1:0] s_sum_a;
    logic [WIDTH-1:0] s_sum_s;
    logic [WIDTH-1:0] s_dbl;
    logic [WIDTH-2:0] n_pa;
    logic [WIDTH-2:0] n_ps;
    logic [WIDTH-2:0] n_addend;

    // Both products share the addend s * 2^k mod m; each multiplier bit,
    // least significant first, decides whether the addend joins its sum.
    // A difference below the modulus always fits the narrower width.
    always_comb begin
        s_mod   = {1'b0, i_modulus};
        s_sum_a = {1'b0, r_pa} + {1'b0, r_addend};
        s_sum_s = {1'b0, r_ps} + {1'b0, r_addend};
        s_dbl   = {r_addend, 1'b0};

        n_pa = r_pa;
        if (r_mul_acc[0]) begin
            if (s_sum_a >= s_mod) begin
                n_pa = s_sum_a[WIDTH-2:0] - s_mod[WIDTH-2:0];
            end else begin
                n_pa = s_sum_a[WIDTH-2:0];
            end
        end

        n_ps = r_ps;
        if (r_mul_sq[0]) begin
            if (s_sum_s >= s_mod) begin
                n_ps = s_sum_s[WIDTH-2:0] - s_mod[WIDTH-2:0];
            end else begin
                n_ps = s_sum_s[WIDTH-2:0];
            end
        end

        if (s_dbl >= s_mod) begin
            n_addend = s_dbl[WIDTH-2:0] - s_mod[WIDTH-2:0];
        end else begin
            n_addend = s_dbl[WIDTH-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_addend  <= i_sq;
            r_mul_acc <= i_acc;
            r_mul_sq  <= i_sq;
            r_pa      <= '0;
            r_ps      <= '0;
        end else if (r_run) begin
            r_addend  <= n_addend;
            r_mul_acc <= {1'b0, r_mul_acc[WIDTH-2:1]};
            r_mul_sq  <= {1'b0, r_mul_sq[WIDTH-2:1]};
            r_pa      <= n_pa;
            r_ps      <= n_ps;
        end
    end

    assign o_done     = r_done;
    assign o_prod_acc = r_pa;
    assign o_prod_sq  = r_ps;

endmodule
